/* rtl/pycc_pkg.sv */
// Package for the pixel to YCoCg-with-alpha converter.
// Holds payload structs, format and register codes, and unpack masks.
// No dependencies.
package pycc_pkg;

	localparam int unsigned PALETTE_ENTRIES_DEF = 256;
	localparam int unsigned PALETTE_WIDTH       = 24;
	localparam int unsigned QUEUE_DEPTH         = 4;

	localparam logic [3:0] FMT_BGRX32   = 4'd0;
	localparam logic [3:0] FMT_BGRA32   = 4'd1;
	localparam logic [3:0] FMT_RGBX32   = 4'd2;
	localparam logic [3:0] FMT_RGBA32   = 4'd3;
	localparam logic [3:0] FMT_BGR24    = 4'd4;
	localparam logic [3:0] FMT_RGB24    = 4'd5;
	localparam logic [3:0] FMT_BGR16    = 4'd6;
	localparam logic [3:0] FMT_RGB16    = 4'd7;
	localparam logic [3:0] FMT_PALETTE8 = 4'd8;

	localparam logic REG_PIXEL_FORMAT     = 1'b0;
	localparam logic REG_COLOR_LOSS_SHIFT = 1'b1;

	localparam logic KIND_CONVERT       = 1'b0;
	localparam logic KIND_PALETTE_WRITE = 1'b1;

	localparam logic [3:0] PIXEL_FORMAT_RESET     = FMT_BGRX32;
	localparam logic [2:0] COLOR_LOSS_SHIFT_RESET = 3'd3;

	localparam logic [7:0] MASK_F8 = 8'hF8;
	localparam logic [7:0] MASK_07 = 8'h07;
	localparam logic [7:0] MASK_1F = 8'h1F;
	localparam logic [7:0] MASK_E0 = 8'hE0;
	localparam logic [7:0] MASK_FF = 8'hFF;

	typedef struct packed {
		logic        kind;
		logic [31:0] pixel_bytes;
		logic [7:0]  palette_index;
		logic [23:0] palette_color;
	} in_t;

	typedef struct packed {
		logic [7:0]        luma;
		logic signed [7:0] chroma_orange;
		logic signed [7:0] chroma_green;
		logic [7:0]        alpha;
	} out_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
	} rgba_t;

	typedef struct packed {
		logic  valid;
		rgba_t data;
	} push_t;

	typedef struct packed {
		logic  valid;
		rgba_t data;
	} head_t;

endpackage

/* rtl/pycc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module pycc_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/pycc_front.sv */
// Front end: accepts beats, writes the palette, reads it for palette8
// pixels and unpacks each pixel into red, green, blue and alpha.
// Depends on pycc_pkg and pycc_ram.
module pycc_front import pycc_pkg::*; #(
	parameter int unsigned PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_t        in_data,
	input  logic [3:0] pixel_format,
	input  logic       queue_full,
	output push_t      push
);

	localparam int unsigned AW = $clog2(PALETTE_ENTRIES);

	logic                     accept;
	logic                     do_push;
	logic                     pal_we;
	logic                     pal_re;
	logic                     wr_hit;
	logic                     rd_hit;
	logic [PALETTE_WIDTH-1:0] pal_rdata;
	logic                     valid_s1;
	logic [31:0]              pixel_bytes_s1;
	logic                     pal_hit_s1;
	logic [7:0]               b0, b1, b2, b3;
	rgba_t                    px;

	assign do_push  = valid_s1 && !queue_full;
	assign in_stall = valid_s1 && queue_full;
	assign accept   = in_valid && !in_stall;

	assign wr_hit = {24'd0, in_data.palette_index} < 32'(PALETTE_ENTRIES);
	assign rd_hit = {24'd0, in_data.pixel_bytes[7:0]} < 32'(PALETTE_ENTRIES);
	assign pal_we = accept && (in_data.kind == KIND_PALETTE_WRITE) && wr_hit;
	assign pal_re = accept && (in_data.kind == KIND_CONVERT);

	pycc_ram #(
		.WIDTH(PALETTE_WIDTH),
		.DEPTH(PALETTE_ENTRIES)
	) u_palette (
		.clk  (clk),
		.we   (pal_we),
		.waddr(in_data.palette_index[AW-1:0]),
		.wdata(in_data.palette_color),
		.re   (pal_re),
		.raddr(in_data.pixel_bytes[AW-1:0]),
		.rdata(pal_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pal_re) begin
			valid_s1 <= 1'b1;
		end else if (do_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pal_re) begin
			pixel_bytes_s1 <= in_data.pixel_bytes;
			pal_hit_s1     <= rd_hit;
		end
	end

	assign b0 = pixel_bytes_s1[7:0];
	assign b1 = pixel_bytes_s1[15:8];
	assign b2 = pixel_bytes_s1[23:16];
	assign b3 = pixel_bytes_s1[31:24];

	always_comb begin
		px = '{r: 8'd0, g: 8'd0, b: 8'd0, a: MASK_FF};
		case (pixel_format)
			FMT_BGRX32, FMT_BGR24: begin
				px.b = b0;
				px.g = b1;
				px.r = b2;
			end
			FMT_BGRA32: begin
				px.b = b0;
				px.g = b1;
				px.r = b2;
				px.a = b3;
			end
			FMT_RGBX32, FMT_RGB24: begin
				px.r = b0;
				px.g = b1;
				px.b = b2;
			end
			FMT_RGBA32: begin
				px.r = b0;
				px.g = b1;
				px.b = b2;
				px.a = b3;
			end
			FMT_BGR16: begin
				px.b = (b1 & MASK_F8) | (b1 >> 5);
				px.g = ((b1 & MASK_07) << 5) | ((b0 & MASK_E0) >> 3);
				px.r = ((b0 & MASK_1F) << 3) | ((b0 >> 2) & MASK_07);
			end
			FMT_RGB16: begin
				px.r = (b1 & MASK_F8) | (b1 >> 5);
				px.g = ((b1 & MASK_07) << 5) | ((b0 & MASK_E0) >> 3);
				px.b = ((b0 & MASK_1F) << 3) | ((b0 >> 2) & MASK_07);
			end
			FMT_PALETTE8: begin
				if (pal_hit_s1) begin
					px.r = pal_rdata[7:0];
					px.g = pal_rdata[15:8];
					px.b = pal_rdata[23:16];
				end
			end
			default: begin
				px.a = 8'd0;
			end
		endcase
	end

	assign push.valid = do_push;
	assign push.data  = px;

endmodule

/* rtl/pycc_queue.sv */
// Short queue of unpacked pixels between the front and back ends.
// Depends on pycc_pkg.
module pycc_queue import pycc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	output logic  full,
	input  logic  pop,
	output head_t head
);

	localparam int unsigned QAW = $clog2(QUEUE_DEPTH);

	rgba_t          entries_q [QUEUE_DEPTH];
	logic [QAW-1:0] wptr_q;
	logic [QAW-1:0] rptr_q;
	logic [QAW:0]   count_q;
	logic           do_pop;

	assign full   = count_q == (QAW+1)'(QUEUE_DEPTH);
	assign do_pop = pop && (count_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push.valid) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push.valid && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push.valid && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			entries_q[wptr_q] <= push.data;
		end
	end

	assign head.valid = count_q != '0;
	assign head.data  = entries_q[rptr_q];

endmodule

/* rtl/pycc_back.sv */
// Back end: computes luma and the loss-shifted chroma with saturation
// and holds the result beat in the output register.
// Depends on pycc_pkg.
module pycc_back import pycc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  head_t      head,
	output logic       pop,
	input  logic [2:0] color_loss_shift,
	output logic       out_valid,
	input  logic       out_stall,
	output out_t       out_data
);

	logic              out_valid_q;
	out_t              out_data_q;
	out_t              res;
	logic [8:0]        y_w;
	logic signed [9:0] co_w, cg_w, co_sh, cg_sh;

	assign pop = head.valid && (!out_valid_q || !out_stall);

	always_comb begin
		y_w = {3'b000, head.data.r[7:2]} + {2'b00, head.data.g[7:1]}
			+ {3'b000, head.data.b[7:2]};
		co_w = $signed({2'b00, head.data.r}) - $signed({2'b00, head.data.b});
		cg_w = $signed({2'b00, head.data.g}) - $signed({3'b000, head.data.r[7:1]})
			- $signed({3'b000, head.data.b[7:1]});
		co_sh = co_w >>> color_loss_shift;
		cg_sh = cg_w >>> color_loss_shift;

		res.luma  = (y_w > 9'd255) ? MASK_FF : y_w[7:0];
		res.alpha = head.data.a;
		if (co_sh > 10'sd127) begin
			res.chroma_orange = 8'sd127;
		end else if (co_sh < -10'sd128) begin
			res.chroma_orange = -8'sd128;
		end else begin
			res.chroma_orange = co_sh[7:0];
		end
		if (cg_sh > 10'sd127) begin
			res.chroma_green = 8'sd127;
		end else if (cg_sh < -10'sd128) begin
			res.chroma_green = -8'sd128;
		end else begin
			res.chroma_green = cg_sh[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

/* rtl/pixel_to_aycocg_converter_unit.sv */
// Top level of the pixel to YCoCg-with-alpha converter.
// Depends on pycc_pkg, pycc_front, pycc_queue and pycc_back.
//
// Takes one beat per clock when not stalled: a palette write (no result)
// or a raw pixel that becomes one beat of luma, orange and green chroma
// and alpha. The front end writes or reads the palette RAM and unpacks
// the pixel in the cycle after acceptance; a four-entry queue decouples
// it from the back end, which computes and registers the result. A pixel
// passes the front-end register, the queue and the output register; the
// sustained rate is one beat per clock, limited only by output stall. The
// palette holds PALETTE_ENTRIES entries and is not cleared at reset. Write
// pixel_format and color_loss_shift only while no beat is in flight.
module pixel_to_aycocg_converter_unit import pycc_pkg::*; #(
	parameter int unsigned PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_t        in_data,
	output logic       out_valid,
	input  logic       out_stall,
	output out_t       out_data,
	input  logic       wr_en,
	input  logic       wr_index,
	input  logic [3:0] wr_data
);

	logic [3:0] pixel_format_q;
	logic [2:0] color_loss_shift_q;
	push_t      push;
	head_t      head;
	logic       queue_full;
	logic       pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_format_q     <= PIXEL_FORMAT_RESET;
			color_loss_shift_q <= COLOR_LOSS_SHIFT_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_PIXEL_FORMAT:     pixel_format_q     <= wr_data;
				REG_COLOR_LOSS_SHIFT: color_loss_shift_q <= wr_data[2:0];
				default: begin
				end
			endcase
		end
	end

	pycc_front #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.pixel_format(pixel_format_q),
		.queue_full  (queue_full),
		.push        (push)
	);

	pycc_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (queue_full),
		.pop   (pop),
		.head  (head)
	);

	pycc_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head            (head),
		.pop             (pop),
		.color_loss_shift(color_loss_shift_q),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_data        (out_data)
	);

endmodule

/* tb/sv/aycocg_checker.sv */
`timescale 1ns / 100ps
// Result checker for pixel_to_aycocg_converter_unit: tracks the registers and
// the palette, predicts each result beat and compares it field by field.
// Depends on pycc_pkg.
module aycocg_checker import pycc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  in_t         in_data,
	input  logic        out_valid,
	input  logic        out_stall,
	input  out_t        out_data,
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [3:0]  wr_data,
	output int unsigned awaiting,
	output int unsigned mismatches,
	output int unsigned converted
);

	localparam int unsigned REPORT_LINES = 40;

	logic [3:0]  pixel_format;
	logic [2:0]  loss_shift;
	logic [23:0] palette [PALETTE_ENTRIES_DEF];
	out_t        expected_colors [$];
	int unsigned fail_total = 0;
	int unsigned checked_total = 0;

	assign mismatches = fail_total;
	assign converted  = checked_total;

	function automatic logic [7:0] wide_field(input logic [7:0] hi);
		return (hi & MASK_F8) | (hi >> 5);
	endfunction

	function automatic logic [7:0] green_field(input logic [7:0] lo, input logic [7:0] hi);
		return ((hi & MASK_07) << 5) | ((lo & MASK_E0) >> 3);
	endfunction

	function automatic logic [7:0] narrow_field(input logic [7:0] lo);
		return ((lo & MASK_1F) << 3) | ((lo >> 2) & MASK_07);
	endfunction

	function automatic logic [7:0] clamp_chroma(input int v);
		if (v < -128)
			return 8'h80;
		if (v > 127)
			return 8'h7F;
		return v[7:0];
	endfunction

	function automatic out_t ycocg_of_pixel(input logic [31:0] px);
		logic [7:0]  r;
		logic [7:0]  g;
		logic [7:0]  b;
		logic [7:0]  a;
		logic [23:0] entry;
		int          ri;
		int          gi;
		int          bi;
		int          y;
		out_t        res;
		r = '0;
		g = '0;
		b = '0;
		a = MASK_FF;
		case (pixel_format)
			FMT_BGRX32, FMT_BGR24: begin
				b = px[7:0];
				g = px[15:8];
				r = px[23:16];
			end
			FMT_BGRA32: begin
				b = px[7:0];
				g = px[15:8];
				r = px[23:16];
				a = px[31:24];
			end
			FMT_RGBX32, FMT_RGB24: begin
				r = px[7:0];
				g = px[15:8];
				b = px[23:16];
			end
			FMT_RGBA32: begin
				r = px[7:0];
				g = px[15:8];
				b = px[23:16];
				a = px[31:24];
			end
			FMT_BGR16: begin
				b = wide_field(px[15:8]);
				g = green_field(px[7:0], px[15:8]);
				r = narrow_field(px[7:0]);
			end
			FMT_RGB16: begin
				r = wide_field(px[15:8]);
				g = green_field(px[7:0], px[15:8]);
				b = narrow_field(px[7:0]);
			end
			FMT_PALETTE8: begin
				entry = palette[px[7:0]];
				r = entry[7:0];
				g = entry[15:8];
				b = entry[23:16];
			end
			default: begin
				a = '0;
			end
		endcase
		ri = int'(r);
		gi = int'(g);
		bi = int'(b);
		y = (ri >> 2) + (gi >> 1) + (bi >> 2);
		res.luma          = (y > 255) ? 8'hFF : y[7:0];
		res.chroma_orange = clamp_chroma((ri - bi) >>> loss_shift);
		res.chroma_green  = clamp_chroma((gi - (ri >> 1) - (bi >> 1)) >>> loss_shift);
		res.alpha         = a;
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		fail_total++;
		if (fail_total <= REPORT_LINES)
			$display("%0t ns checker: result beat %0d: %s", $time, checked_total, msg);
	endtask

	task automatic compare_field(input string name, input logic [7:0] got,
		input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %02h want %02h", name, got, want));
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			pixel_format = PIXEL_FORMAT_RESET;
			loss_shift   = COLOR_LOSS_SHIFT_RESET;
			expected_colors.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_colors.size() == 0) begin
					report_mismatch("beat with no result expected");
				end else begin
					want = expected_colors.pop_front();
					compare_field("luma", out_data.luma, want.luma);
					compare_field("chroma_orange", out_data.chroma_orange, want.chroma_orange);
					compare_field("chroma_green", out_data.chroma_green, want.chroma_green);
					compare_field("alpha", out_data.alpha, want.alpha);
					checked_total++;
				end
			end
			if (in_valid && !in_stall) begin
				if (in_data.kind == KIND_PALETTE_WRITE)
					palette[in_data.palette_index] = in_data.palette_color;
				else
					expected_colors.push_back(ycocg_of_pixel(in_data.pixel_bytes));
			end
			if (wr_en) begin
				case (wr_index)
					REG_PIXEL_FORMAT: pixel_format = wr_data;
					REG_COLOR_LOSS_SHIFT: loss_shift = wr_data[2:0];
					default: ;
				endcase
			end
		end
		awaiting <= expected_colors.size();
	end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// Testbench top for pixel_to_aycocg_converter_unit: clock, reset, input beats,
// register writes, receiver stall and the verdict.
// Depends on pycc_pkg, the unit and aycocg_checker.
module tb_top;
	import pycc_pkg::*;

	localparam int unsigned RESET_CYCLES   = 10;
	localparam int unsigned DRAIN_CYCLES   = 8;
	localparam int unsigned LONG_HOLD      = 48;
	localparam int unsigned PHASE_BEATS    = 85;
	localparam int unsigned PHASES         = 12;
	localparam int unsigned PRESSURE_PHASE = 1;
	localparam logic [3:0]  FMT_UNSUPPORTED     = 4'd9;
	localparam logic [3:0]  FMT_UNSUPPORTED_TOP = 4'd15;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_e;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_t         in_data;
	logic        out_valid;
	logic        out_stall;
	out_t        out_data;
	logic        wr_en;
	logic        wr_index;
	logic [3:0]  wr_data;

	int unsigned awaiting;
	int unsigned mismatches;
	int unsigned converted;

	int unsigned burst_left;
	int unsigned gap_max;
	int unsigned pixels_sent = 0;
	int unsigned palette_writes = 0;
	int unsigned settings_used = 1;
	int unsigned holds_done = 0;
	bit          hold_req = 1'b0;
	bit          palette_written [256];
	logic [7:0]  written_list [$];

	logic [3:0] phase_format [PHASES] = '{FMT_BGRA32, FMT_RGBA32, FMT_BGR24, FMT_RGB24,
		FMT_BGR16, FMT_RGB16, FMT_PALETTE8, FMT_UNSUPPORTED, FMT_UNSUPPORTED_TOP,
		FMT_BGRX32, FMT_RGBX32, FMT_PALETTE8};
	logic [3:0] phase_loss [PHASES] = '{4'd7, 4'd0, 4'd1, 4'd2, 4'd4, 4'd5, 4'd6, 4'd3,
		4'hF, 4'h8, 4'd3, 4'd0};

	always #6 clk = ~clk;

	pixel_to_aycocg_converter_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data)
	);

	aycocg_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.awaiting   (awaiting),
		.mismatches (mismatches),
		.converted  (converted)
	);

	task automatic offer_beat(input in_t beat);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		in_valid <= 1'b1;
		in_data  <= beat;
		do @(posedge clk); while (in_stall);
		burst_left--;
	endtask

	task automatic send_pixel(input logic [31:0] px);
		in_t beat;
		beat.kind          = KIND_CONVERT;
		beat.pixel_bytes   = px;
		beat.palette_index = 8'($urandom);
		beat.palette_color = 24'($urandom);
		offer_beat(beat);
		pixels_sent++;
	endtask

	task automatic send_palette(input logic [7:0] idx, input logic [23:0] color);
		in_t beat;
		beat.kind          = KIND_PALETTE_WRITE;
		beat.pixel_bytes   = $urandom;
		beat.palette_index = idx;
		beat.palette_color = color;
		offer_beat(beat);
		palette_writes++;
		if (!palette_written[idx]) begin
			palette_written[idx] = 1'b1;
			written_list.push_back(idx);
		end
	endtask

	// drop valid, wait for the last result, then let trailing palette writes retire
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (awaiting != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic set_registers(input logic [3:0] format_code, input logic [3:0] loss);
		wr_en    <= 1'b1;
		wr_index <= REG_PIXEL_FORMAT;
		wr_data  <= format_code;
		@(posedge clk);
		wr_index <= REG_COLOR_LOSS_SHIFT;
		wr_data  <= loss;
		@(posedge clk);
		wr_en    <= 1'b0;
		settings_used++;
	endtask

	initial begin : receiver
		stall_mode_e stall_mode;
		int unsigned mode_left;
		int unsigned tick;
		out_stall <= 1'b0;
		stall_mode = STALL_NONE;
		mode_left  = 0;
		tick       = 0;
		forever begin
			@(posedge clk);
			tick++;
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
				holds_done++;
			end
			if (mode_left == 0) begin
				stall_mode = stall_mode_e'($urandom_range(0, 3));
				mode_left  = $urandom_range(50, 300);
			end
			mode_left--;
			case (stall_mode)
				STALL_NONE: out_stall <= 1'b0;
				STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= ((tick % 8) >= 5);
			endcase
		end
	end

	initial begin : stimulus
		logic [31:0] px;
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		in_data    <= '0;
		wr_en      <= 1'b0;
		wr_index   <= REG_PIXEL_FORMAT;
		wr_data    <= '0;
		burst_left = 0;
		gap_max    = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_palette(8'h00, 24'h000000);
		send_palette(8'hFF, 24'hFFFFFF);
		send_palette(8'h5A, 24'hE1C3A5);
		send_palette(8'h80, 24'h0000FF);
		send_palette(8'h81, 24'hFF0000);
		send_pixel(32'h0000_0000);
		send_pixel(32'hFFFF_FFFF);
		send_pixel(32'h00FF_0000);
		send_pixel(32'h0000_00FF);
		send_pixel(32'h0000_FF00);
		send_pixel(32'h8080_8080);
		// saturate both chroma channels with no loss shift
		settle();
		set_registers(FMT_RGBX32, 4'd0);
		send_pixel(32'h0000_00FF);
		send_pixel(32'h00FF_0000);
		send_pixel(32'h0000_FF00);
		send_pixel(32'h00FF_00FF);
		settle();
		set_registers(FMT_UNSUPPORTED, 4'd7);
		send_pixel(32'hFFFF_FFFF);
		settle();
		set_registers(FMT_PALETTE8, 4'd3);
		send_pixel(32'hFFFF_FF00);
		send_pixel(32'h0000_00FF);
		send_pixel(32'h5A5A_5A5A);
		send_pixel(32'h0000_0080);
		send_pixel(32'h0000_0081);

		for (int p = 0; p < PHASES; p++) begin
			settle();
			set_registers(phase_format[p], phase_loss[p]);
			if (p == PRESSURE_PHASE)
				gap_max = 0;
			else
				gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
			if (p == PRESSURE_PHASE)
				hold_req = 1'b1;
			repeat (PHASE_BEATS) begin
				if ($urandom_range(0, 4) == 0) begin
					send_palette(8'($urandom), 24'($urandom));
				end else begin
					px = $urandom;
					if ($urandom_range(0, 3) == 0) begin
						for (int i = 0; i < 4; i++) begin
							case ($urandom_range(0, 2))
								0: px[8*i +: 8] = 8'h00;
								1: px[8*i +: 8] = 8'hFF;
								default: ;
							endcase
						end
					end
					// palette lookups only hit entries already written
					if (phase_format[p] == FMT_PALETTE8)
						px[7:0] = written_list[$urandom_range(0, written_list.size() - 1)];
					send_pixel(px);
				end
			end
		end

		settle();
		$display("run covered %0d pixel beats (%0d results checked) and %0d palette writes",
			pixels_sent, converted, palette_writes);
		$display("over %0d register settings, with %0d long receiver hold-offs",
			settings_used, holds_done);
		if (mismatches == 0)
			$display("[pixel_to_aycocg_converter_unit] OK");
		else
			$display("[pixel_to_aycocg_converter_unit] ERROR");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("timeout with %0d results outstanding", awaiting);
		$display("[pixel_to_aycocg_converter_unit] ERROR");
		$finish;
	end

endmodule
